// ----- design/lap3_pkg.sv -----
package lap3_pkg;

   localparam int MAX_LINE_WIDTH   = 1024;
   localparam int MAX_FRAME_HEIGHT = 1024;

   localparam int COL_W    = $clog2(MAX_LINE_WIDTH);
   localparam int CFG_W    = 11;
   localparam int ROW_W    = 11;
   localparam int WEIGHT_W = 4;
   localparam int CMP_W    = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
   localparam int CH_W     = 8;
   localparam int PIX_W    = 3 * CH_W;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_WIDTH    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTRE_WEIGHT = 2'd2;

   localparam logic [CFG_W-1:0]    LINE_WIDTH_RESET    = 11'd640;
   localparam logic [CFG_W-1:0]    FRAME_HEIGHT_RESET  = 11'd500;
   localparam logic [WEIGHT_W-1:0] CENTRE_WEIGHT_RESET = 4'd8;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [CMP_W-1:0]    width;
      logic [ROW_W-1:0]    height;
      logic [WEIGHT_W-1:0] weight;
   } cfg_type;

   typedef struct packed {
      logic [COL_W-1:0] column;
      logic             drain;
      logic             first_column;
      logic             emit;
      logic             frame_end;
      logic [PIX_W-1:0] pixel;
   } cmd_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic            frame_last;
   } rsp_type;

endpackage

// ----- design/lap3_front.sv -----
module lap3_front
   import lap3_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            req_push,
   output logic            req_full,
   input  logic            req_operation,
   input  logic [CH_W-1:0] req_red_in,
   input  logic [CH_W-1:0] req_green_in,
   input  logic [CH_W-1:0] req_blue_in,
   input  logic            queue_full,
   output logic            cmd_push,
   output cmd_type         cmd
);

   logic [COL_W-1:0] column_ff, column_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [CFG_W-1:0] pending_ff, pending_in;
   logic             accept;
   logic             is_drain;
   logic             take;
   logic             wrap;
   logic [CMP_W-1:0] column_next;
   logic [ROW_W-1:0] row_inc;

   always_comb begin
      req_full    = queue_full;
      accept      = req_push && !queue_full;
      is_drain    = req_operation == OP_DRAIN;
      take        = accept && (is_drain ? (pending_ff != '0) : (pending_ff == '0));
      column_next = CMP_W'(column_ff) + CMP_W'(1);
      wrap        = column_next >= cfg.width;
      row_inc     = row_ff + ROW_W'(1);

      cmd.column       = column_ff;
      cmd.drain        = is_drain;
      cmd.first_column = column_ff == '0;
      cmd.emit         = (column_ff == '0) ? (row_ff >= ROW_W'(2)) : (row_ff != '0);
      cmd.frame_end    = 1'b0;
      cmd.pixel        = {req_red_in, req_green_in, req_blue_in};

      column_in  = column_ff;
      row_in     = row_ff;
      pending_in = pending_ff;

      if (take) begin
         if (wrap) begin
            column_in = '0;
            row_in    = row_inc;
         end else begin
            column_in = column_next[COL_W-1:0];
         end
         if (!is_drain) begin
            if (wrap && (row_inc >= cfg.height)) begin
               pending_in = CFG_W'(cfg.width + CMP_W'(1));
            end
         end else begin
            pending_in = pending_ff - CFG_W'(1);
            if (pending_ff == CFG_W'(1)) begin
               column_in     = '0;
               row_in        = '0;
               cmd.frame_end = 1'b1;
            end
         end
      end
      cmd_push = take;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff  <= '0;
         row_ff     <= '0;
         pending_ff <= '0;
      end else begin
         column_ff  <= column_in;
         row_ff     <= row_in;
         pending_ff <= pending_in;
      end
   end

`ifndef SYNTHESIS
   a_flush_returns_home: assert property (@(posedge clock) disable iff (reset)
      (take && is_drain && pending_ff == CFG_W'(1)) |=>
      (column_ff == '0 && row_ff == '0 && pending_ff == '0))
      else $error("positions not cleared at the end of a flush");
`endif

endmodule

// ----- design/lap3_cmd_queue.sv -----
module lap3_cmd_queue
   import lap3_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   cmd_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   always_comb begin
      full      = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
      empty     = count_ff == '0;
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      count_in = count_ff + QUEUE_CNT_W'(do_push) - QUEUE_CNT_W'(do_pop);
      pop_data = entries_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("command taken from an empty queue");
`endif

endmodule

// ----- design/lap3_back.sv -----
module lap3_back
   import lap3_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   cmd_empty,
   input  cmd_type                cmd,
   output logic                   cmd_pop,
   input  logic [QUEUE_CNT_W-1:0] rsp_level,
   output logic                   rsp_push,
   output rsp_type                rsp
);

   typedef logic [2:0][PIX_W-1:0] column_type;

   function automatic logic [CH_W-1:0] filter_channel(
      input logic [2:0][2:0][CH_W-1:0] taps,
      input logic [WEIGHT_W-1:0]       weight
   );
      logic [CH_W+WEIGHT_W-1:0]      product;
      logic [CH_W+2:0]               neighbours;
      logic signed [CH_W+WEIGHT_W:0] total;
      logic [CH_W-1:0]               result;
      int                            c;
      int                            r;
      product    = (CH_W + WEIGHT_W)'(weight) * (CH_W + WEIGHT_W)'(taps[1][1]);
      neighbours = '0;
      for (c = 0; c < 3; c++) begin
         for (r = 0; r < 3; r++) begin
            if (c != 1 || r != 1) begin
               neighbours = neighbours + (CH_W + 3)'(taps[c][r]);
            end
         end
      end
      total = $signed({1'b0, product}) - $signed({2'b00, neighbours});
      if (total < 0) begin
         result = '0;
      end else if (total > $signed((CH_W + WEIGHT_W + 1)'(255))) begin
         result = '1;
      end else begin
         result = total[CH_W-1:0];
      end
      return result;
   endfunction

   logic [2*PIX_W-1:0] line_mem [MAX_LINE_WIDTH];
   logic [2*PIX_W-1:0] rdata_ff;
   logic [2*PIX_W-1:0] bypass_data_ff;
   logic               bypass_ff;
   logic               b2_valid_ff;
   cmd_type            b2_cmd_ff;
   column_type         mid_col_ff, mid_col_in;
   column_type         right_col_ff, right_col_in;
   logic [COL_W-1:0]   ocol_ff, ocol_in;
   logic [ROW_W-1:0]   orow_ff, orow_in;

   logic [QUEUE_CNT_W:0]          credit_used;
   logic                          issue;
   logic [2*PIX_W-1:0]            line_word;
   logic [PIX_W-1:0]              up2;
   logic [PIX_W-1:0]              up1;
   logic                          mem_write;
   logic [2*PIX_W-1:0]            mem_wdata;
   column_type                    new_col;
   logic [2:0][2:0][PIX_W-1:0]    win;
   logic [2:0][2:0][2:0][CH_W-1:0] chan_taps;
   logic                          left_clamp;
   logic                          right_clamp;
   logic                          top_clamp;
   logic                          bot_clamp;
   logic [CMP_W-1:0]              ocol_next;
   logic [ROW_W:0]                orow_inc;
   logic                          emit;

   always_comb begin
      credit_used = (QUEUE_CNT_W + 1)'(rsp_level) + (QUEUE_CNT_W + 1)'(b2_valid_ff);
      issue       = !cmd_empty && (credit_used < (QUEUE_CNT_W + 1)'(QUEUE_DEPTH));
      cmd_pop     = issue;

      line_word = bypass_ff ? bypass_data_ff : rdata_ff;
      up2       = line_word[2*PIX_W-1:PIX_W];
      up1       = line_word[PIX_W-1:0];
      mem_write = b2_valid_ff && !b2_cmd_ff.drain;
      mem_wdata = {up1, b2_cmd_ff.pixel};

      new_col[0] = up2;
      new_col[1] = up1;
      new_col[2] = b2_cmd_ff.drain ? up1 : b2_cmd_ff.pixel;

      ocol_next   = CMP_W'(ocol_ff) + CMP_W'(1);
      orow_inc    = {1'b0, orow_ff} + (ROW_W + 1)'(1);
      left_clamp  = ocol_ff == '0;
      right_clamp = ocol_next >= cfg.width;
      top_clamp   = orow_ff == '0;
      bot_clamp   = orow_inc >= {1'b0, cfg.height};

      win[0] = left_clamp ? right_col_ff : mid_col_ff;
      win[1] = right_col_ff;
      win[2] = (right_clamp || b2_cmd_ff.first_column) ? right_col_ff : new_col;
      for (int c = 0; c < 3; c++) begin
         if (top_clamp) begin
            win[c][0] = win[c][1];
         end
         if (bot_clamp) begin
            win[c][2] = win[c][1];
         end
      end

      for (int k = 0; k < 3; k++) begin
         for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
               chan_taps[k][c][r] = win[c][r][PIX_W-1-CH_W*k -: CH_W];
            end
         end
      end

      emit           = b2_valid_ff && b2_cmd_ff.emit;
      rsp_push       = emit;
      rsp.red        = filter_channel(chan_taps[0], cfg.weight);
      rsp.green      = filter_channel(chan_taps[1], cfg.weight);
      rsp.blue       = filter_channel(chan_taps[2], cfg.weight);
      rsp.frame_last = bot_clamp && right_clamp;

      mid_col_in   = mid_col_ff;
      right_col_in = right_col_ff;
      ocol_in      = ocol_ff;
      orow_in      = orow_ff;
      if (b2_valid_ff) begin
         mid_col_in   = right_col_ff;
         right_col_in = new_col;
      end
      if (emit) begin
         if (right_clamp) begin
            ocol_in = '0;
            orow_in = orow_inc[ROW_W-1:0];
         end else begin
            ocol_in = ocol_next[COL_W-1:0];
         end
      end
      if (b2_valid_ff && b2_cmd_ff.frame_end) begin
         ocol_in = '0;
         orow_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_write) begin
         line_mem[b2_cmd_ff.column] <= mem_wdata;
      end
      if (issue) begin
         rdata_ff <= line_mem[cmd.column];
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         b2_cmd_ff      <= cmd;
         bypass_ff      <= mem_write && (b2_cmd_ff.column == cmd.column);
         bypass_data_ff <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b2_valid_ff  <= 1'b0;
         mid_col_ff   <= '0;
         right_col_ff <= '0;
         ocol_ff      <= '0;
         orow_ff      <= '0;
      end else begin
         b2_valid_ff  <= issue;
         mid_col_ff   <= mid_col_in;
         right_col_ff <= right_col_in;
         ocol_ff      <= ocol_in;
         orow_ff      <= orow_in;
      end
   end

`ifndef SYNTHESIS
   a_output_home_after_flush: assert property (@(posedge clock) disable iff (reset)
      (b2_valid_ff && b2_cmd_ff.frame_end) |=> (ocol_ff == '0 && orow_ff == '0))
      else $error("output position not cleared at the end of a flush");
`endif

endmodule

// ----- design/lap3_rsp_queue.sv -----
module lap3_rsp_queue
   import lap3_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  rsp_type                push_data,
   output logic [QUEUE_CNT_W-1:0] level,
   input  logic                   pop,
   output rsp_type                pop_data,
   output logic                   empty
);

   rsp_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   full;
   logic                   do_push;
   logic                   do_pop;

   always_comb begin
      full      = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
      empty     = count_ff == '0;
      level     = count_ff;
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      count_in = count_ff + QUEUE_CNT_W'(do_push) - QUEUE_CNT_W'(do_pop);
      pop_data = entries_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("result written into a full queue");

   a_level_step: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> count_ff == $past(count_ff) + QUEUE_CNT_W'(1))
      else $error("result queue level out of step");
`endif

endmodule

// ----- design/laplacian_3x3_filter_unit.sv -----
// Path: the request that completes a window, one line and one pixel after the pixel it belongs to,
// passes the command queue, the b2 register of the back end and the result queue to the rsp ports.
// Throughput: one request per clock cycle while both queues have room, set by the line store, which
// is read once in the issue cycle and written once in the following cycle for every pixel request.
// Reset: synchronous and active high; it restores 640 x 500 with centre weight 8, empties both
// queues and clears all positions, while the line store contents are left as they are.
module laplacian_3x3_filter_unit
   import lap3_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic                   req_operation,
   input  logic [CH_W-1:0]        req_red_in,
   input  logic [CH_W-1:0]        req_green_in,
   input  logic [CH_W-1:0]        req_blue_in,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [CH_W-1:0]        rsp_red_out,
   output logic [CH_W-1:0]        rsp_green_out,
   output logic [CH_W-1:0]        rsp_blue_out,
   output logic                   rsp_frame_last,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_data
);

   logic [CFG_W-1:0]       line_width_ff, line_width_in;
   logic [CFG_W-1:0]       frame_height_ff, frame_height_in;
   logic [WEIGHT_W-1:0]    centre_weight_ff, centre_weight_in;
   cfg_type                cfg;
   logic                   cmd_push;
   cmd_type                cmd_in;
   logic                   cmd_full;
   logic                   cmd_pop;
   cmd_type                cmd_head;
   logic                   cmd_empty;
   logic                   rsp_push;
   rsp_type                rsp_in;
   rsp_type                rsp_head;
   logic [QUEUE_CNT_W-1:0] rsp_level;

   always_comb begin
      line_width_in    = line_width_ff;
      frame_height_in  = frame_height_ff;
      centre_weight_in = centre_weight_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_LINE_WIDTH: begin
               line_width_in = csr_data;
            end
            CSR_FRAME_HEIGHT: begin
               frame_height_in = csr_data;
            end
            CSR_CENTRE_WEIGHT: begin
               centre_weight_in = csr_data[WEIGHT_W-1:0];
            end
            default: begin
            end
         endcase
      end

      if (line_width_ff == '0) begin
         cfg.width = CMP_W'(1);
      end else if (CMP_W'(line_width_ff) > CMP_W'(MAX_LINE_WIDTH)) begin
         cfg.width = CMP_W'(MAX_LINE_WIDTH);
      end else begin
         cfg.width = CMP_W'(line_width_ff);
      end

      if (frame_height_ff == '0) begin
         cfg.height = ROW_W'(1);
      end else if (frame_height_ff > ROW_W'(MAX_FRAME_HEIGHT)) begin
         cfg.height = ROW_W'(MAX_FRAME_HEIGHT);
      end else begin
         cfg.height = frame_height_ff;
      end

      cfg.weight = centre_weight_ff;

      rsp_red_out    = rsp_head.red;
      rsp_green_out  = rsp_head.green;
      rsp_blue_out   = rsp_head.blue;
      rsp_frame_last = rsp_head.frame_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff    <= LINE_WIDTH_RESET;
         frame_height_ff  <= FRAME_HEIGHT_RESET;
         centre_weight_ff <= CENTRE_WEIGHT_RESET;
      end else begin
         line_width_ff    <= line_width_in;
         frame_height_ff  <= frame_height_in;
         centre_weight_ff <= centre_weight_in;
      end
   end

   lap3_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_operation (req_operation),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .queue_full    (cmd_full),
      .cmd_push      (cmd_push),
      .cmd           (cmd_in)
   );

   lap3_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_head),
      .empty     (cmd_empty)
   );

   lap3_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_empty (cmd_empty),
      .cmd       (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_level (rsp_level),
      .rsp_push  (rsp_push),
      .rsp       (rsp_in)
   );

   lap3_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in),
      .level     (rsp_level),
      .pop       (rsp_pop),
      .pop_data  (rsp_head),
      .empty     (rsp_empty)
   );

endmodule
